>>> rtl/core/slmp_pkg.sv
// Shared types and constants for the sound level meter polling host.
// Holds the request and result structs, operation and result codes, and the
// command byte table. No dependencies.
`default_nettype none

package slmp_pkg;

	localparam int LIMIT_BITS = 24;
	localparam int SAMPLE_COUNT_BITS_DEF = 24;

	localparam logic [1:0] OP_TX_SLOT = 2'd0;
	localparam logic [1:0] OP_RX_BYTE = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] KIND_TX = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_INIT_ERR = 2'd2;
	localparam logic [1:0] KIND_DATA_ERR = 2'd3;

	localparam logic [7:0] INIT_ACK = 8'h05;
	localparam logic [7:0] REPLY_END = 8'h0d;
	localparam logic [7:0] DATA_MARK = 8'h01;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [10:0] level_tenths;
		logic        weight_c;
		logic        slow_response;
		logic [1:0]  range_code;
		logic        limit_reached;
		logic        last;
	} res_t;

	// Everything one request produces; a command expands to three bytes.
	typedef struct packed {
		logic [1:0]  kind;
		logic        is_req;
		logic [10:0] level_tenths;
		logic        weight_c;
		logic        slow_response;
		logic [1:0]  range_code;
		logic        limit_reached;
	} burst_t;

	// Init command is 10 04 0d, data request is 30 00 0d.
	function automatic logic [7:0] cmd_byte(input logic is_req, input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = is_req ? 8'h30 : 8'h10;
			2'd1: b = is_req ? 8'h00 : 8'h04;
			default: b = 8'h0d;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/slmp_ctrl.sv
// Protocol state machine of the polling host: command phases, reply checks,
// sample decode and the saturating sample counter. Depends on slmp_pkg.
`default_nettype none

module slmp_ctrl import slmp_pkg::*; #(
	parameter int COUNT_BITS = SAMPLE_COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  take,
	input  wire req_t                  item,
	input  wire logic [LIMIT_BITS-1:0] sample_limit,
	output logic                       emit,
	output burst_t                     burst
);

	localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

	typedef enum logic [2:0] {
		ISSUE_INIT,
		WAIT_INIT,
		SEND_REQ,
		WAIT_DATA,
		STOPPED
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [1:0]            idx_q, idx_d;
	logic                  mism_q, mism_d;
	logic [COUNT_BITS-1:0] count_q, count_d, count_inc;
	logic [7:0]            held0_q, held1_q;
	logic                  bad_byte;

	assign count_inc = (&count_q) ? count_q : count_q + COUNT_BITS'(1);

	always_comb begin
		phase_d = phase_q;
		idx_d = idx_q;
		mism_d = mism_q;
		count_d = count_q;
		emit = 1'b0;
		burst = '0;
		bad_byte = 1'b0;
		case (item.opcode)
			OP_RESTART: begin
				phase_d = ISSUE_INIT;
				idx_d = 2'd0;
				mism_d = 1'b0;
				count_d = '0;
			end
			OP_TX_SLOT: begin
				if (phase_q == ISSUE_INIT || phase_q == SEND_REQ) begin
					emit = 1'b1;
					burst.kind = KIND_TX;
					burst.is_req = (phase_q == SEND_REQ);
					phase_d = (phase_q == SEND_REQ) ? WAIT_DATA : WAIT_INIT;
					idx_d = 2'd0;
					mism_d = 1'b0;
				end
			end
			OP_RX_BYTE: begin
				unique case (phase_q)
					WAIT_INIT: begin
						if (idx_q == 2'd0) begin
							mism_d = mism_q | (item.rx_byte != INIT_ACK);
							idx_d = 2'd1;
						end else begin
							idx_d = 2'd0;
							mism_d = 1'b0;
							if (mism_q || item.rx_byte != REPLY_END) begin
								phase_d = ISSUE_INIT;
								emit = 1'b1;
								burst.kind = KIND_INIT_ERR;
							end else begin
								phase_d = SEND_REQ;
							end
						end
					end
					WAIT_DATA: begin
						unique case (idx_q)
							2'd0, 2'd1: bad_byte = 1'b0;
							2'd2: bad_byte = (item.rx_byte != DATA_MARK);
							2'd3: bad_byte = (item.rx_byte != REPLY_END);
						endcase
						if (idx_q != 2'd3) begin
							idx_d = idx_q + 2'd1;
							mism_d = mism_q | bad_byte;
						end else begin
							idx_d = 2'd0;
							mism_d = 1'b0;
							phase_d = SEND_REQ;
							emit = 1'b1;
							if (mism_q || bad_byte) begin
								burst.kind = KIND_DATA_ERR;
							end else begin
								count_d = count_inc;
								burst.kind = KIND_SAMPLE;
								burst.level_tenths = {held0_q[2:0], held1_q};
								burst.weight_c = held0_q[7];
								burst.slow_response = held0_q[3];
								burst.range_code = held0_q[5:4];
								if (sample_limit != '0 &&
								    CMP_BITS'(count_inc) >= CMP_BITS'(sample_limit)) begin
									burst.limit_reached = 1'b1;
									phase_d = STOPPED;
								end
							end
						end
					end
					ISSUE_INIT, SEND_REQ, STOPPED: begin
						phase_d = phase_q;
					end
					default: phase_d = phase_q;
				endcase
			end
			default: phase_d = phase_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ISSUE_INIT;
			idx_q <= 2'd0;
			mism_q <= 1'b0;
			count_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			mism_q <= mism_d;
			count_q <= count_d;
		end
	end

	// The first two data reply bytes are held for the decode on the last byte.
	always_ff @(posedge clk) begin
		if (take && item.opcode == OP_RX_BYTE && phase_q == WAIT_DATA) begin
			if (idx_q == 2'd0) held0_q <= item.rx_byte;
			if (idx_q == 2'd1) held1_q <= item.rx_byte;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sound_meter_poll_protocol_core.sv
// Sound level meter polling host, top level. Depends on slmp_pkg, slmp_ctrl.
// The first result of a request is offered in the cycle after accept.
// Throughput: one request per cycle while each causes at most one result, with no
// output stall; a command request holds the output register for its three results.
// Reset clears the phase to the init command phase, the counters and the sample limit.
`default_nettype none

module sound_meter_poll_protocol_core import slmp_pkg::*; #(
	parameter int SAMPLE_COUNT_BITS = SAMPLE_COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire req_t                  in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output res_t                       out_data,
	input  wire logic                  cfg_we,
	input  wire logic [LIMIT_BITS-1:0] cfg_data
);

	logic [LIMIT_BITS-1:0] limit_q;
	logic                  take, emit, last_res;
	burst_t                burst, burst_s1;
	logic                  valid_s1;
	logic [1:0]            sub_q;

	slmp_ctrl #(
		.COUNT_BITS(SAMPLE_COUNT_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.item        (in_data),
		.sample_limit(limit_q),
		.emit        (emit),
		.burst       (burst)
	);

	assign last_res = (burst_s1.kind != KIND_TX) || (sub_q == 2'd2);
	assign in_ready = !valid_s1 || (out_ready && last_res);
	assign take = in_valid && in_ready;
	assign out_valid = valid_s1;

	always_comb begin
		out_data = '0;
		out_data.kind = burst_s1.kind;
		out_data.tx_byte = (burst_s1.kind == KIND_TX) ? cmd_byte(burst_s1.is_req, sub_q) : 8'h00;
		out_data.level_tenths = burst_s1.level_tenths;
		out_data.weight_c = burst_s1.weight_c;
		out_data.slow_response = burst_s1.slow_response;
		out_data.range_code = burst_s1.range_code;
		out_data.limit_reached = burst_s1.limit_reached;
		out_data.last = last_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			valid_s1 <= 1'b0;
			sub_q <= 2'd0;
		end else begin
			if (cfg_we) limit_q <= cfg_data;
			// A new request may load as the previous one's final result leaves.
			if (take && emit) begin
				valid_s1 <= 1'b1;
				sub_q <= 2'd0;
			end else if (valid_s1 && out_ready) begin
				if (last_res) valid_s1 <= 1'b0;
				else sub_q <= sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) burst_s1 <= burst;
	end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for sound_meter_poll_protocol_core: a directed request table, then
// random exchanges with random idling, checked against a local model of the meter host.
// Depends on slmp_pkg and the core RTL.
`default_nettype none

module tb_top;
	import slmp_pkg::*;

	localparam int COUNT_BITS = SAMPLE_COUNT_BITS_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [23:0] INIT_CMD = 24'h10040d;
	localparam logic [23:0] POLL_CMD = 24'h30000d;
	localparam int IDLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 80;
	localparam int N_DIRECTED = 25;
	localparam int N_PHASES = 6;

	typedef enum logic [2:0] {
		PH_ISSUE_INIT, PH_WAIT_INIT, PH_SEND_REQ, PH_WAIT_DATA, PH_STOPPED
	} meter_phase_t;

	// One row of the directed table; e0..e2 are used only when typed is set.
	typedef struct packed {
		req_t       r;
		bit         typed;
		logic [1:0] n;
		res_t       e0;
		res_t       e1;
		res_t       e2;
	} drow_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	res_t out_data;
	logic cfg_we;
	logic [LIMIT_BITS-1:0] cfg_data;

	// Host model state.
	meter_phase_t m_phase = PH_ISSUE_INIT;
	logic [1:0] m_idx = '0;
	logic [7:0] m_held [2];
	logic m_bad = 1'b0;
	logic [COUNT_BITS-1:0] m_count = '0;
	logic [LIMIT_BITS-1:0] m_limit = '0;

	res_t step_res [3];
	int step_n;
	bit step_live;

	res_t pending_results [$];
	int errors = 0;
	int n_reqs = 0, n_samples = 0, n_init_err = 0, n_data_err = 0, n_stops = 0, n_holds = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	drow_t plan [N_DIRECTED];

	sound_meter_poll_protocol_core #(.SAMPLE_COUNT_BITS(COUNT_BITS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	function automatic res_t tx_res(input logic [7:0] b, input logic lst);
		res_t x;
		x = '0;
		x.kind = KIND_TX;
		x.tx_byte = b;
		x.last = lst;
		return x;
	endfunction

	function automatic res_t err_res(input logic [1:0] k);
		res_t x;
		x = '0;
		x.kind = k;
		x.last = 1'b1;
		return x;
	endfunction

	function automatic res_t sample_res(input logic [10:0] lv, input logic wc, input logic sl,
			input logic [1:0] rg);
		res_t x;
		x = '0;
		x.kind = KIND_SAMPLE;
		x.level_tenths = lv;
		x.weight_c = wc;
		x.slow_response = sl;
		x.range_code = rg;
		x.last = 1'b1;
		return x;
	endfunction

	function automatic drow_t row(input logic [1:0] op, input logic [7:0] b, input bit typed,
			input logic [1:0] n, input res_t a, input res_t c, input res_t d);
		drow_t x;
		x.r.opcode = op;
		x.r.rx_byte = b;
		x.typed = typed;
		x.n = n;
		x.e0 = a;
		x.e1 = c;
		x.e2 = d;
		return x;
	endfunction

	task automatic put_cmd(input logic [23:0] cmd, input meter_phase_t next);
		step_res[0] = tx_res(cmd[23:16], 1'b0);
		step_res[1] = tx_res(cmd[15:8], 1'b0);
		step_res[2] = tx_res(cmd[7:0], 1'b1);
		step_n = 3;
		m_idx = '0;
		m_bad = 1'b0;
		m_phase = next;
	endtask

	// Advances the host model by one request and leaves its results in step_res.
	task automatic meter_step(input req_t r);
		logic lim;
		step_n = 0;
		step_live = 1'b1;
		case (r.opcode)
			OP_RESTART: begin
				m_phase = PH_ISSUE_INIT;
				m_idx = '0;
				m_bad = 1'b0;
				m_count = '0;
			end
			OP_TX_SLOT: begin
				if (m_phase == PH_ISSUE_INIT) begin
					put_cmd(INIT_CMD, PH_WAIT_INIT);
				end else if (m_phase == PH_SEND_REQ) begin
					put_cmd(POLL_CMD, PH_WAIT_DATA);
				end else begin
					step_live = 1'b0;
				end
			end
			OP_RX_BYTE: begin
				if (m_phase == PH_WAIT_INIT) begin
					if (m_idx == 2'd0) begin
						m_bad = m_bad | (r.rx_byte != INIT_ACK);
						m_idx = 2'd1;
					end else begin
						m_bad = m_bad | (r.rx_byte != REPLY_END);
						m_idx = '0;
						if (m_bad) begin
							m_bad = 1'b0;
							m_phase = PH_ISSUE_INIT;
							step_res[0] = err_res(KIND_INIT_ERR);
							step_n = 1;
							n_init_err++;
						end else begin
							m_phase = PH_SEND_REQ;
						end
					end
				end else if (m_phase == PH_WAIT_DATA) begin
					if (m_idx < 2'd2) begin
						m_held[m_idx[0]] = r.rx_byte;
					end else if (m_idx == 2'd2) begin
						m_bad = m_bad | (r.rx_byte != DATA_MARK);
					end else begin
						m_bad = m_bad | (r.rx_byte != REPLY_END);
					end
					if (m_idx != 2'd3) begin
						m_idx = m_idx + 2'd1;
					end else begin
						m_idx = '0;
						m_phase = PH_SEND_REQ;
						step_n = 1;
						if (m_bad) begin
							m_bad = 1'b0;
							step_res[0] = err_res(KIND_DATA_ERR);
							n_data_err++;
						end else begin
							if (m_count != '1)
								m_count = m_count + 1'b1;
							// The limit is tested only when a sample is counted.
							lim = (m_limit != '0) && (m_count >= m_limit);
							if (lim) begin
								m_phase = PH_STOPPED;
								n_stops++;
							end
							step_res[0] = sample_res({m_held[0][2:0], m_held[1]}, m_held[0][7],
								m_held[0][3], m_held[0][5:4]);
							step_res[0].limit_reached = lim;
							n_samples++;
						end
					end
				end else begin
					step_live = 1'b0;
				end
			end
			default: begin
				step_live = 1'b0;
			end
		endcase
	endtask

	// Mostly well-formed exchanges with random payload, plus some noise and broken replies.
	function automatic req_t next_req();
		req_t r;
		int p;
		p = $urandom_range(0, 99);
		r.opcode = OP_RX_BYTE;
		r.rx_byte = 8'($urandom_range(0, 255));
		if (p < 8) begin
			r.opcode = 2'($urandom_range(0, 3));
			return r;
		end
		case (m_phase)
			PH_ISSUE_INIT, PH_SEND_REQ: begin
				r.opcode = OP_TX_SLOT;
			end
			PH_WAIT_INIT: begin
				if (p >= 14)
					r.rx_byte = (m_idx == 2'd0) ? INIT_ACK : REPLY_END;
			end
			PH_WAIT_DATA: begin
				if (m_idx == 2'd2 && p >= 14)
					r.rx_byte = DATA_MARK;
				else if (m_idx == 2'd3 && p >= 14)
					r.rx_byte = REPLY_END;
			end
			default: begin
				r.opcode = (p < 50) ? OP_RESTART : OP_TX_SLOT;
			end
		endcase
		return r;
	endfunction

	task automatic cmp_field(input string name, input logic [10:0] want, input logic [10:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Offers one request after a gap, waits for it to be taken, then records what it should cause.
	task automatic push_req(input drow_t d, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d.r;
		do @(posedge clk); while (!in_ready);
		n_reqs++;
		meter_step(d.r);
		if (d.typed) begin
			step_n = d.n;
			step_res[0] = d.e0;
			step_res[1] = d.e1;
			step_res[2] = d.e2;
		end
		for (int k = 0; k < step_n; k++)
			pending_results.push_back(step_res[k]);
	endtask

	task automatic drain_out();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// A request with no result may still be in flight.
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [LIMIT_BITS-1:0] v);
		drain_out();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_limit = v;
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %h", $time, out_data);
			end else begin
				want = pending_results.pop_front();
				cmp_field("kind", 11'(want.kind), 11'(out_data.kind));
				cmp_field("tx_byte", 11'(want.tx_byte), 11'(out_data.tx_byte));
				cmp_field("level_tenths", want.level_tenths, out_data.level_tenths);
				cmp_field("weight_c", 11'(want.weight_c), 11'(out_data.weight_c));
				cmp_field("slow_response", 11'(want.slow_response),
					11'(out_data.slow_response));
				cmp_field("range_code", 11'(want.range_code), 11'(out_data.range_code));
				cmp_field("limit_reached", 11'(want.limit_reached),
					11'(out_data.limit_reached));
				cmp_field("last", 11'(want.last), 11'(out_data.last));
			end
		end
	end

	initial begin : result_sink
		int stall;
		out_ready <= 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 16);
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
				n_holds++;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin : request_source
		logic [LIMIT_BITS-1:0] limits [N_PHASES];
		int quota [N_PHASES];
		int done;
		int gap;
		int w;
		bit paused;
		drow_t d;

		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;

		plan[0] = row(OP_RX_BYTE, 8'h00, 1, 0, '0, '0, '0);
		plan[1] = row(OP_UNUSED, 8'hff, 1, 0, '0, '0, '0);
		plan[2] = row(OP_TX_SLOT, 8'h00, 1, 3, tx_res(8'h10, 0), tx_res(8'h04, 0),
			tx_res(8'h0d, 1));
		plan[3] = row(OP_TX_SLOT, 8'h00, 1, 0, '0, '0, '0);
		plan[4] = row(OP_RX_BYTE, INIT_ACK, 1, 0, '0, '0, '0);
		plan[5] = row(OP_RX_BYTE, 8'hff, 1, 1, err_res(KIND_INIT_ERR), '0, '0);
		plan[6] = row(OP_TX_SLOT, 8'h00, 1, 3, tx_res(8'h10, 0), tx_res(8'h04, 0),
			tx_res(8'h0d, 1));
		plan[7] = row(OP_RX_BYTE, 8'h00, 1, 0, '0, '0, '0);
		plan[8] = row(OP_RX_BYTE, REPLY_END, 1, 1, err_res(KIND_INIT_ERR), '0, '0);
		plan[9] = row(OP_TX_SLOT, 8'h00, 0, 0, '0, '0, '0);
		plan[10] = row(OP_RX_BYTE, INIT_ACK, 1, 0, '0, '0, '0);
		plan[11] = row(OP_RX_BYTE, REPLY_END, 1, 0, '0, '0, '0);
		plan[12] = row(OP_TX_SLOT, 8'h00, 1, 3, tx_res(8'h30, 0), tx_res(8'h00, 0),
			tx_res(8'h0d, 1));
		plan[13] = row(OP_RX_BYTE, 8'hff, 1, 0, '0, '0, '0);
		plan[14] = row(OP_RX_BYTE, 8'hff, 1, 0, '0, '0, '0);
		plan[15] = row(OP_RX_BYTE, DATA_MARK, 1, 0, '0, '0, '0);
		plan[16] = row(OP_RX_BYTE, REPLY_END, 1, 1, sample_res(11'h7ff, 1, 1, 2'd3), '0, '0);
		plan[17] = row(OP_TX_SLOT, 8'h00, 0, 0, '0, '0, '0);
		plan[18] = row(OP_RX_BYTE, 8'h9c, 0, 0, '0, '0, '0);
		plan[19] = row(OP_RX_BYTE, 8'h42, 0, 0, '0, '0, '0);
		plan[20] = row(OP_RX_BYTE, 8'h00, 1, 0, '0, '0, '0);
		plan[21] = row(OP_RX_BYTE, REPLY_END, 1, 1, err_res(KIND_DATA_ERR), '0, '0);
		plan[22] = row(OP_TX_SLOT, 8'h00, 0, 0, '0, '0, '0);
		plan[23] = row(OP_RX_BYTE, 8'h00, 0, 0, '0, '0, '0);
		// Restart in the middle of a data reply.
		plan[24] = row(OP_RESTART, 8'h00, 1, 0, '0, '0, '0);

		limits[0] = 24'd3;
		limits[1] = 24'd0;
		limits[2] = 24'd2;
		limits[3] = 24'hffffff;
		limits[4] = 24'd1;
		limits[5] = 24'd5;
		quota[0] = 20;
		quota[1] = 25;
		quota[2] = 10;
		quota[3] = 25;
		quota[4] = 20;
		quota[5] = 20;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			push_req(plan[i], $urandom_range(0, 16));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// With no restart in between, the limit of 2 is likely below the count already.
			set_limit(limits[ph]);
			quiet = (ph == 1);
			if (ph == 3)
				hold_req = 1'b1;
			done = 0;
			paused = 1'b0;
			while (done < quota[ph]) begin
				if (ph == 1 && done == 15 && !paused) begin
					drain_out();
					paused = 1'b1;
				end
				gap = (quiet || ph == 3) ? 0 : $urandom_range(0, 16);
				d = '0;
				d.r = next_req();
				push_req(d, gap);
				if (step_live)
					done++;
			end
		end

		in_valid <= 1'b0;
		for (w = 0; w < 5000 && pending_results.size() != 0; w++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
		end
		$display("Sent %0d requests over %0d limit settings: %0d samples, %0d init and %0d data",
			n_reqs, N_PHASES, n_samples, n_init_err, n_data_err);
		$display("reply errors, %0d stops on the limit, %0d long output stalls.", n_stops, n_holds);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
